[sv/incremental_pid_deadband_clamp_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the incremental PID block
// Shared wrappers so every module writes its checks in one form.
// ---------------------------------------------------------------------------
`ifndef INCREMENTAL_PID_DEADBAND_CLAMP_ASSERT_SVH
`define INCREMENTAL_PID_DEADBAND_CLAMP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define IPID_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define IPID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ipid_pkg.sv]
// ---------------------------------------------------------------------------
// ipid_pkg
// Shared constants, register codes and types of the incremental PID block.
// ---------------------------------------------------------------------------
package ipid_pkg;

  // Default number of fraction bits in gains and accumulator.
  localparam int FRACTION_BITS_DEF = 8;

  // Field widths.
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int LIMIT_W  = 16;
  localparam int DRIVE_W  = 16;
  localparam int ERR_W    = SAMPLE_W + 1;
  localparam int STEP_W   = ERR_W + 1;
  localparam int CURV_W   = STEP_W + 1;

  // Product widths of the three terms.
  localparam int TERM_P_W = GAIN_W + STEP_W;
  localparam int TERM_I_W = GAIN_W + ERR_W;
  localparam int TERM_D_W = GAIN_W + CURV_W;

  // Wide enough for the accumulator (at most 32 bits) plus the sum of terms.
  localparam int SUM_W = 37;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_DEADBAND  = 3'd3,
    REG_DRIVE_MAX = 3'd4,
    REG_DRIVE_MIN = 3'd5
  } ipid_reg_t;

  // Register reset values.
  localparam logic signed [GAIN_W-1:0]  GAIN_P_RST    = 16'sd256;
  localparam logic signed [GAIN_W-1:0]  GAIN_I_RST    = 16'sd0;
  localparam logic signed [GAIN_W-1:0]  GAIN_D_RST    = 16'sd0;
  localparam logic        [15:0]        DEADBAND_RST  = 16'd0;
  localparam logic signed [LIMIT_W-1:0] DRIVE_MAX_RST = 16'sd10000;
  localparam logic signed [LIMIT_W-1:0] DRIVE_MIN_RST = -16'sd10000;

  // Control handed from the term stage to the accumulator stage.
  typedef struct packed {
    logic load;   // a beat moves into the result register
    logic hold;   // error inside the deadband: no update
  } ipid_ctrl_t;

endpackage

[sv/ipid_accum.sv]
// ---------------------------------------------------------------------------
// ipid_accum
// Adds the registered PID terms to the drive accumulator, clamps it and
// registers the integer part as the drive result.
// ---------------------------------------------------------------------------
`include "incremental_pid_deadband_clamp_assert.svh"

module ipid_accum
  import ipid_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ipid_ctrl_t                 ctrl,
  input  logic signed [TERM_P_W-1:0] term_p,
  input  logic signed [TERM_I_W-1:0] term_i,
  input  logic signed [TERM_D_W-1:0] term_d,
  input  logic signed [LIMIT_W-1:0]  drive_max,
  input  logic signed [LIMIT_W-1:0]  drive_min,
  output logic signed [DRIVE_W-1:0]  drive
);

  localparam int ACC_W = LIMIT_W + FRACTION_BITS;
  localparam logic signed [SUM_W-1:0] RND_BIAS = SUM_W'((1 << FRACTION_BITS) - 1);

  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [DRIVE_W-1:0] drive_r, drive_nxt;
  logic signed [SUM_W-1:0]   acc_ext, terms, sum, hi_ext, lo_ext;
  logic signed [SUM_W-1:0]   sum_rnd, acc_rnd;
  logic                      at_hi, at_lo;

  // Limits scaled into accumulator units.
  assign hi_ext  = SUM_W'(drive_max) <<< FRACTION_BITS;
  assign lo_ext  = SUM_W'(drive_min) <<< FRACTION_BITS;
  assign acc_ext = SUM_W'(acc_r);

  // Sum of the three terms, skipped inside the deadband.
  assign terms = SUM_W'(term_p) + SUM_W'(term_i) + SUM_W'(term_d);
  assign sum   = ctrl.hold ? acc_ext : (acc_ext + terms);

  // Integer part truncated toward zero, formed beside the clamp compares.
  assign sum_rnd = (sum + ((sum < 0) ? RND_BIAS : '0)) >>> FRACTION_BITS;

  // Upper limit is tested first; the lower one only if that fails.
  always_comb begin
    at_hi = (sum >= hi_ext);
    at_lo = (sum <= lo_ext);
    if (at_hi) begin
      acc_nxt   = ACC_W'(hi_ext);
      drive_nxt = drive_max;
    end else if (at_lo) begin
      acc_nxt   = ACC_W'(lo_ext);
      drive_nxt = drive_min;
    end else begin
      acc_nxt   = ACC_W'(sum);
      drive_nxt = DRIVE_W'(sum_rnd);
    end
  end

  // Accumulator and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      drive_r <= '0;
    end else if (ctrl.load) begin
      acc_r   <= acc_nxt;
      drive_r <= drive_nxt;
    end
  end

  assign drive = drive_r;

  // Integer part of the stored accumulator, used by the checks below.
  assign acc_rnd = (acc_ext + ((acc_ext < 0) ? RND_BIAS : '0)) >>> FRACTION_BITS;

  `IPID_ASSERT_NOW(a_drive_matches_acc, 1'b1, drive_r == DRIVE_W'(acc_rnd),
    "drive register disagrees with the accumulator")
  `IPID_ASSERT_NEXT(a_clamp_range, ctrl.load && (lo_ext <= hi_ext),
    (acc_ext >= $past(lo_ext)) && (acc_ext <= $past(hi_ext)),
    "accumulator left the clamp range")
  `IPID_ASSERT_NEXT(a_deadband_hold,
    ctrl.load && ctrl.hold && (acc_ext >= lo_ext) && (acc_ext <= hi_ext),
    acc_r == $past(acc_r), "accumulator moved inside the deadband")

endmodule

[sv/incremental_pid_deadband_clamp.sv]
// ---------------------------------------------------------------------------
// incremental_pid_deadband_clamp
// Velocity-form PID controller with error deadband and drive clamp.
// ---------------------------------------------------------------------------
//  Channel  Dir  Payload (low bit up)              Handshake
//  in_      in   setpoint[15:0], measured[31:16]   tvalid/tready
//  out_     out  drive[15:0]                       tvalid/tready
//  cfg_     in   addr = register index, wdata      we, no wait
//
//  One beat is accepted every cycle while the output is not stalled; a
//  sample loads the input register at the accepting edge, then the term
//  register, then the result register that holds its drive.
//  The three gain multiplies sit between the input and term registers; the
//  accumulate and clamp sit between the term and result registers.
//  Reset (rst_n low, synchronous) clears the error history, the accumulator
//  and loads the register defaults. A stalled output holds back each stage
//  only when the stage after it is full.
// ---------------------------------------------------------------------------
`include "incremental_pid_deadband_clamp_assert.svh"

module incremental_pid_deadband_clamp
  import ipid_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Sample channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,   // setpoint[15:0], measured[31:16]
  // Drive channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // drive[15:0]
  // Configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers
  logic signed [GAIN_W-1:0]  gain_p_r, gain_i_r, gain_d_r;
  logic        [15:0]        deadband_r;
  logic signed [LIMIT_W-1:0] drive_max_r, drive_min_r;

  // Pipeline control
  logic       in_v_r, term_v_r, out_v_r;
  logic       in_move, term_ready, out_load;
  ipid_ctrl_t ctrl;

  // Input register
  logic signed [SAMPLE_W-1:0] setpoint_r, measured_r;

  // Error history
  logic signed [ERR_W-1:0]  last_error_r, error;
  logic signed [STEP_W-1:0] last_step_r, step;
  logic signed [CURV_W-1:0] curve;
  logic signed [STEP_W-1:0] err_ext, db_ext;
  logic                     hold_nxt;

  // Term register
  logic signed [TERM_P_W-1:0] term_p_r;
  logic signed [TERM_I_W-1:0] term_i_r;
  logic signed [TERM_D_W-1:0] term_d_r;
  logic                       hold_r;
  logic signed [DRIVE_W-1:0]  drive;

  // Register writes; unused indexes fall through.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r    <= GAIN_P_RST;
      gain_i_r    <= GAIN_I_RST;
      gain_d_r    <= GAIN_D_RST;
      deadband_r  <= DEADBAND_RST;
      drive_max_r <= DRIVE_MAX_RST;
      drive_min_r <= DRIVE_MIN_RST;
    end else if (cfg_we) begin
      case (ipid_reg_t'(cfg_addr))
        REG_GAIN_P:    gain_p_r    <= cfg_wdata;
        REG_GAIN_I:    gain_i_r    <= cfg_wdata;
        REG_GAIN_D:    gain_d_r    <= cfg_wdata;
        REG_DEADBAND:  deadband_r  <= cfg_wdata;
        REG_DRIVE_MAX: drive_max_r <= cfg_wdata;
        REG_DRIVE_MIN: drive_min_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Each stage moves when the next one is empty or moving too.
  assign out_load   = term_v_r && (!out_v_r || out_tready);
  assign term_ready = !term_v_r || out_load;
  assign in_move    = in_v_r && term_ready;
  assign in_tready  = !in_v_r || in_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r       <= 1'b0;
      term_v_r     <= 1'b0;
      out_v_r      <= 1'b0;
      last_error_r <= '0;
      last_step_r  <= '0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (term_ready) begin
        term_v_r <= in_v_r;
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (in_move) begin
        last_error_r <= error;
        last_step_r  <= step;
      end
    end
  end

  // Error, first and second difference.
  assign error = ERR_W'(setpoint_r) - ERR_W'(measured_r);
  assign step  = STEP_W'(error) - STEP_W'(last_error_r);
  assign curve = CURV_W'(step) - CURV_W'(last_step_r);

  // Deadband test: strictly inside plus or minus the deadband.
  assign err_ext  = STEP_W'(error);
  assign db_ext   = $signed({2'b00, deadband_r});
  assign hold_nxt = (err_ext < db_ext) && (err_ext > -db_ext);

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      setpoint_r <= in_tdata[15:0];
      measured_r <= in_tdata[31:16];
    end
    if (in_move) begin
      term_p_r <= TERM_P_W'(gain_p_r) * TERM_P_W'(step);
      term_i_r <= TERM_I_W'(gain_i_r) * TERM_I_W'(error);
      term_d_r <= TERM_D_W'(gain_d_r) * TERM_D_W'(curve);
      hold_r   <= hold_nxt;
    end
  end

  assign ctrl.load = out_load;
  assign ctrl.hold = hold_r;

  ipid_accum #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .term_p    (term_p_r),
    .term_i    (term_i_r),
    .term_d    (term_d_r),
    .drive_max (drive_max_r),
    .drive_min (drive_min_r),
    .drive     (drive)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = drive;

  `IPID_ASSERT_NOW(a_ready_only_full, !in_tready, in_v_r && term_v_r && out_v_r,
    "input stalled while the pipeline has room")
  `IPID_ASSERT_NEXT(a_term_follows, in_move, term_v_r,
    "sample left the input register but the term stage is empty")
  `IPID_ASSERT_NEXT(a_term_holds, term_v_r && !term_ready,
    term_v_r && $stable(term_p_r) && $stable(hold_r),
    "term stage changed while held")

endmodule
